[rtl/laplacian_five_point_stencil_macros.svh]
// assertion macros shared by the five-point stencil rtl
`ifndef LAPLACIAN_FIVE_POINT_STENCIL_MACROS_SVH
`define LAPLACIAN_FIVE_POINT_STENCIL_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define LAP5_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define LAP5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lap5_pkg.sv]
// package: defaults, field widths and result slot codes of the five-point stencil
`default_nettype none

package lap5_pkg;

  // default build parameters
  localparam int MAX_GRID_DEFAULT    = 256;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  // grid_size register
  localparam int GRID_SIZE_BITS  = 9;
  localparam int GRID_SIZE_RESET = 64;

  // row and column fields of a result
  localparam int COORD_BITS = 8;

  // result slot codes, in delivery order within one input beat
  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_ABOVE = 2'd0;  // point above the sample
  localparam slot_t SLOT_LEFT  = 2'd1;  // point left of the sample, last row
  localparam slot_t SLOT_LAST  = 2'd2;  // final point of the frame

endpackage

`default_nettype wire

[rtl/lap5_ram.sv]
// generic ram: one write port, two registered read ports
`default_nettype none

module lap5_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[rtl/laplacian_five_point_stencil.sv]
// top level: five-point laplacian stencil over a raster grid stream
`default_nettype none

// Samples of an n-by-n grid enter in raster order on the s_ side, one per beat, and
// results leave on the m_ side as 4*centre minus each in-grid neighbour (zero boundary),
// tagged with row and column; tlast marks the final result of a frame. The result for
// point (r-1,c) appears after sample (r,c) is taken, so the first row gives no results;
// on the last row each sample also releases the point to its left, and the last sample
// releases the last point too. While m_tready is high, rows 0 to n-2 take one sample per
// clock. On the last row the sample in column 0 yields one result, every later sample
// two, and the final one three (a single-point grid gives just one); the single result
// register sends one per clock under that condition; a sample waits until at most
// one result is left. Columns are kept in one dual-read line ram of MAX_GRID words of
// two samples each, read one column ahead; it needs no clearing pass after reset. A
// write on the cfg channel sets n (0 acts as 1, above MAX_GRID acts as MAX_GRID) and
// restarts the frame at row 0, column 0; write it only while no results are pending.
module laplacian_five_point_stencil #(
  parameter int MAX_GRID    = lap5_pkg::MAX_GRID_DEFAULT,
  parameter int SAMPLE_BITS = lap5_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // grid_size write
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [lap5_pkg::GRID_SIZE_BITS-1:0]        cfg_data,
  // sample beats
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,  // sample
  // result beats
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [((SAMPLE_BITS+3+2*lap5_pkg::COORD_BITS+7)/8)*8-1:0]
                                                     m_tdata,  // result_value, result_row,
                                                               // result_column
  output logic                                       m_tlast   // frame_end
);

  import lap5_pkg::*;

  `include "laplacian_five_point_stencil_macros.svh"

  localparam int AW       = $clog2(MAX_GRID);
  localparam int NW       = AW + 1;
  localparam int OUT_BITS = SAMPLE_BITS + 3;
  localparam int OUT_TW   = ((OUT_BITS + 2*COORD_BITS + 7) / 8) * 8;
  localparam int N_RESET  = (GRID_SIZE_RESET > MAX_GRID) ? MAX_GRID : GRID_SIZE_RESET;

  // handshakes
  logic cfg_we;
  logic acc;
  logic out_acc;

  // configuration and position
  logic [NW-1:0] grid_n;
  logic [NW-1:0] cfg_n;
  logic [AW-1:0] row;
  logic [AW-1:0] col;
  logic [AW-1:0] row_next;
  logic [AW-1:0] col_next;
  logic [AW-1:0] col_sel;
  logic          last_col;
  logic          last_row;

  // line ram and bypass
  logic [2*SAMPLE_BITS-1:0] ram_q0;
  logic [2*SAMPLE_BITS-1:0] ram_q1;
  logic [2*SAMPLE_BITS-1:0] d0;
  logic [2*SAMPLE_BITS-1:0] d1;
  logic [2*SAMPLE_BITS-1:0] wr_data;
  logic [2*SAMPLE_BITS-1:0] wq;
  logic [AW-1:0]            rd_a0;
  logic [AW-1:0]            rd_a1;
  logic                     byp0;
  logic                     byp1;

  // stencil window
  logic signed [SAMPLE_BITS-1:0] x_s;
  logic signed [SAMPLE_BITS-1:0] up_c;     // row r-1, column c
  logic signed [SAMPLE_BITS-1:0] up_r;     // row r-1, column c+1
  logic signed [SAMPLE_BITS-1:0] up2_c;    // row r-2, column c
  logic signed [SAMPLE_BITS-1:0] up_l;     // row r-1, column c-1
  logic signed [SAMPLE_BITS-1:0] left1;    // row r, column c-1
  logic signed [SAMPLE_BITS-1:0] left2;    // row r, column c-2

  logic signed [OUT_BITS-1:0] e_x;
  logic signed [OUT_BITS-1:0] e_up_c;
  logic signed [OUT_BITS-1:0] e_up_r;
  logic signed [OUT_BITS-1:0] e_up2_c;
  logic signed [OUT_BITS-1:0] e_up_l;
  logic signed [OUT_BITS-1:0] e_left1;
  logic signed [OUT_BITS-1:0] e_left2;
  logic signed [OUT_BITS-1:0] v_above;
  logic signed [OUT_BITS-1:0] v_left;
  logic signed [OUT_BITS-1:0] v_last;
  logic [2:0]                 new_mask;

  // result register
  logic [2:0]                res_mask;
  logic [OUT_BITS-1:0]       res_value [3];
  logic [COORD_BITS-1:0]     res_row   [3];
  logic [COORD_BITS-1:0]     res_col   [3];
  slot_t                     sel;

  // handshake logic
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign s_tready  = (res_mask == 3'b000) ||
                     (m_tready && ((res_mask & (res_mask - 3'b001)) == 3'b000));
  assign acc       = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;

  // clamp of a grid_size write
  always_comb begin
    if (cfg_data == '0) begin
      cfg_n = NW'(1);
    end else if (32'(cfg_data) > MAX_GRID) begin
      cfg_n = NW'(MAX_GRID);
    end else begin
      cfg_n = NW'(cfg_data);
    end
  end

  // raster position
  assign last_col = (NW'(col) + NW'(1)) == grid_n;
  assign last_row = (NW'(row) + NW'(1)) == grid_n;

  always_comb begin
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : AW'(row + 1'b1);
    end else begin
      col_next = AW'(col + 1'b1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_n <= NW'(N_RESET);
      row    <= '0;
      col    <= '0;
    end else if (cfg_we) begin
      grid_n <= cfg_n;
      row    <= '0;
      col    <= '0;
    end else if (acc) begin
      row    <= row_next;
      col    <= col_next;
    end
  end

  // read one column ahead of the beat that will sit on the input next cycle
  always_comb begin
    if (cfg_we) begin
      col_sel = '0;
    end else if (acc) begin
      col_sel = col_next;
    end else begin
      col_sel = col;
    end
  end

  assign rd_a0 = col_sel;
  assign rd_a1 = AW'(col_sel + 1'b1);

  // each word holds {row r-2, row r-1} of its column; a beat pushes its sample in
  assign wr_data = {d0[SAMPLE_BITS-1:0], s_tdata[SAMPLE_BITS-1:0]};

  lap5_ram #(
    .WIDTH (2*SAMPLE_BITS),
    .DEPTH (MAX_GRID)
  ) u_line (
    .clk     (clk),
    .we      (acc),
    .waddr   (col),
    .wdata   (wr_data),
    .raddr_a (rd_a0),
    .rdata_a (ram_q0),
    .raddr_b (rd_a1),
    .rdata_b (ram_q1)
  );

  // write-to-read bypass around the ram
  always_ff @(posedge clk) begin
    if (rst) begin
      byp0 <= 1'b0;
      byp1 <= 1'b0;
    end else begin
      byp0 <= acc && (rd_a0 == col);
      byp1 <= acc && (rd_a1 == col);
    end
  end

  always_ff @(posedge clk) begin
    wq <= wr_data;
  end

  assign d0 = byp0 ? wq : ram_q0;
  assign d1 = byp1 ? wq : ram_q1;

  // window registers along the row
  always_ff @(posedge clk) begin
    if (acc) begin
      up_l  <= up_c;
      left1 <= x_s;
      left2 <= left1;
    end
  end

  assign x_s   = s_tdata[SAMPLE_BITS-1:0];
  assign up_c  = d0[SAMPLE_BITS-1:0];
  assign up2_c = d0[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign up_r  = d1[SAMPLE_BITS-1:0];

  assign e_x     = OUT_BITS'(x_s);
  assign e_up_c  = OUT_BITS'(up_c);
  assign e_up_r  = OUT_BITS'(up_r);
  assign e_up2_c = OUT_BITS'(up2_c);
  assign e_up_l  = OUT_BITS'(up_l);
  assign e_left1 = OUT_BITS'(left1);
  assign e_left2 = OUT_BITS'(left2);

  // stencil sums, neighbours outside the grid count as zero
  assign v_above = (e_up_c <<< 2) - e_x
                 - ((col != '0) ? e_up_l : '0)
                 - (!last_col ? e_up_r : '0)
                 - ((NW'(row) >= NW'(2)) ? e_up2_c : '0);

  assign v_left  = (e_left1 <<< 2) - e_x
                 - ((NW'(col) >= NW'(2)) ? e_left2 : '0)
                 - ((row != '0) ? e_up_l : '0);

  assign v_last  = (e_x <<< 2)
                 - ((col != '0) ? e_left1 : '0)
                 - ((row != '0) ? e_up_c : '0);

  assign new_mask[SLOT_ABOVE] = (row != '0);
  assign new_mask[SLOT_LEFT]  = last_row && (col != '0);
  assign new_mask[SLOT_LAST]  = last_row && last_col;

  // result register control
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      res_mask <= 3'b000;
    end else if (acc) begin
      res_mask <= new_mask;
    end else if (out_acc) begin
      res_mask <= res_mask & ~(res_mask & (~res_mask + 3'b001));
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (acc) begin
      res_value[SLOT_ABOVE] <= v_above;
      res_row[SLOT_ABOVE]   <= COORD_BITS'(AW'(row - 1'b1));
      res_col[SLOT_ABOVE]   <= COORD_BITS'(col);
      res_value[SLOT_LEFT]  <= v_left;
      res_row[SLOT_LEFT]    <= COORD_BITS'(row);
      res_col[SLOT_LEFT]    <= COORD_BITS'(AW'(col - 1'b1));
      res_value[SLOT_LAST]  <= v_last;
      res_row[SLOT_LAST]    <= COORD_BITS'(row);
      res_col[SLOT_LAST]    <= COORD_BITS'(col);
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    if (res_mask[SLOT_ABOVE]) begin
      sel = SLOT_ABOVE;
    end else if (res_mask[SLOT_LEFT]) begin
      sel = SLOT_LEFT;
    end else begin
      sel = SLOT_LAST;
    end
  end

  assign m_tvalid = (res_mask != 3'b000);
  assign m_tlast  = (sel == SLOT_LAST);
  assign m_tdata  = OUT_TW'({res_col[sel], res_row[sel], res_value[sel]});

  // checks
  `LAP5_ASSERT_NOW(a_pos_in_grid, 1'b1, (NW'(col) < grid_n) && (NW'(row) < grid_n), "position outside the grid")
  `LAP5_ASSERT_NOW(a_take_when_drained, acc, (res_mask == 3'b000) || (out_acc && ($countones(res_mask) == 1)), "sample taken over pending results")
  `LAP5_ASSERT_NEXT(a_first_row_silent, acc && (row == '0) && !last_row, res_mask == 3'b000, "first row gave a result")
  `LAP5_ASSERT_NEXT(a_frame_end_due, acc && last_row && last_col, res_mask[SLOT_LAST], "final point not queued")

endmodule

`default_nettype wire
